@@ hw/rtl/bmalloc_pkg.sv @@
`timescale 1ns / 1ps

package bmalloc_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int WORD_BITS_DEF   = 32;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int STATUS_W = 2;
  // Bit positions reached by a scan stay below the count limit plus one word.
  localparam int BASE_W   = CNT_W + 1;

  localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

  localparam logic [OP_W-1:0] OP_GET   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd5;
  localparam logic [OP_W-1:0] OP_CLAIM = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

  typedef struct packed {
    logic take;
    logic rd_single;
    logic exec_single;
    logic scan_run;
    logic clear_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_scan;
    logic hit;
    logic scan_end;
  } dp_stat_t;

endpackage

@@ hw/rtl/bmalloc_in_if.sv @@
`timescale 1ns / 1ps

interface bmalloc_in_if;
  import bmalloc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  index;
  logic              value;
  logic              search_clear;

  modport source (output valid, operation, index, value, search_clear, input ready);
  modport sink   (input valid, operation, index, value, search_clear, output ready);
endinterface

@@ hw/rtl/bmalloc_out_if.sv @@
`timescale 1ns / 1ps

interface bmalloc_out_if;
  import bmalloc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                bit_value;
  logic                changed;
  logic [IDX_W-1:0]    found_index;

  modport source (output valid, status, bit_value, changed, found_index, input ready);
  modport sink   (input valid, status, bit_value, changed, found_index, output ready);
endinterface

@@ hw/rtl/bmalloc_ctrl.sv @@
`timescale 1ns / 1ps

module bmalloc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bmalloc_pkg::dp_stat_t stat,
  output bmalloc_pkg::dp_cmd_t  cmd
);
  import bmalloc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = stat.op_scan ? S_SCAN : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_single = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec_single = 1'b1;
        state_nxt       = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/bmalloc_dp.sv @@
`timescale 1ns / 1ps

module bmalloc_dp #(
  parameter int MAX_ENTRIES = bmalloc_pkg::MAX_ENTRIES_DEF,
  parameter int WORD_BITS   = bmalloc_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bmalloc_pkg::dp_cmd_t             cmd,
  output bmalloc_pkg::dp_stat_t            stat,
  input  logic                             cfg_we,
  input  logic [bmalloc_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic [bmalloc_pkg::OP_W-1:0]     in_operation,
  input  logic [bmalloc_pkg::IDX_W-1:0]    in_index,
  input  logic                             in_value,
  input  logic                             in_search_clear,
  output logic [bmalloc_pkg::STATUS_W-1:0] out_status,
  output logic                             out_bit_value,
  output logic                             out_changed,
  output logic [bmalloc_pkg::IDX_W-1:0]    out_found_index
);
  import bmalloc_pkg::*;

  localparam int NUM_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_SPAN  = 1 << IDX_W;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int LIM       = (MAX_ENTRIES < CNT_MAX) ? MAX_ENTRIES : CNT_MAX;
  localparam logic [CNT_W-1:0]  LIM_C   = CNT_W'(LIM);
  localparam logic [WIDX_W-1:0] LAST_W  = WIDX_W'(NUM_WORDS - 1);
  localparam logic [BASE_W-1:0] WORD_SZ = BASE_W'(WORD_BITS);

  // Configuration and the live entry count.
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  live_n;
  logic [BASE_W-1:0] live_n_w;

  // Request fields held for the duration of an item.
  logic [OP_W-1:0]  op_r;
  logic [IDX_W-1:0] idx_r;
  logic             val_r;
  logic             sclr_r;

  // Word and bit position of every possible index.
  logic [WIDX_W-1:0] q_tab [IDX_SPAN];
  logic [BIT_W-1:0]  r_tab [IDX_SPAN];

  // Bitmap storage.
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 we;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Clearing pass after reset.
  logic [WIDX_W-1:0] clr_ptr_r;

  // Scan pipeline: one word read per cycle, processed the cycle after.
  logic [WIDX_W-1:0]  rp_r;
  logic [BASE_W-1:0]  rbase_r;
  logic               dv_r;
  logic [WIDX_W-1:0]  pw_r;
  logic [BASE_W-1:0]  pb_r;
  logic [BIT_W:0]     plim_r;
  logic               issue;
  logic [BASE_W-1:0]  rem;
  logic [BIT_W:0]     plim_nxt;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic               want;
  logic [BIT_W-1:0]   ff;
  logic               hit;
  logic               scan_end;
  logic [BASE_W-1:0]  found_sum;

  // Single-entry path.
  logic [WIDX_W-1:0]    s_word;
  logic [BIT_W-1:0]     s_bit;
  logic                 s_in_range;
  logic                 s_old;
  logic                 s_nv;
  logic                 s_modify;
  logic [WORD_BITS-1:0] s_new_word;
  logic [WORD_BITS-1:0] fill_word;
  logic [WORD_BITS-1:0] claim_word;

  // Result of the item in progress.
  logic [STATUS_W-1:0] res_status_r;
  logic                res_bit_r;
  logic                res_chg_r;
  logic [IDX_W-1:0]    res_found_r;

  for (genvar g = 0; g < IDX_SPAN; g++) begin : g_tab
    assign q_tab[g] = WIDX_W'(g / WORD_BITS);
    assign r_tab[g] = BIT_W'(g % WORD_BITS);
  end

  assign live_n   = (cnt_r > LIM_C) ? LIM_C : cnt_r;
  assign live_n_w = BASE_W'(live_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_operation;
      idx_r  <= in_index;
      val_r  <= in_value;
      sclr_r <= in_search_clear;
    end
  end

  // Single-entry request.
  always_comb begin
    s_word     = q_tab[idx_r];
    s_bit      = r_tab[idx_r];
    s_in_range = CNT_W'(idx_r) < live_n;
    s_old      = rd_data_r[s_bit];
    case (op_r)
      OP_SET:   s_nv = 1'b1;
      OP_CLEAR: s_nv = 1'b0;
      default:  s_nv = val_r;
    endcase
    s_modify   = s_in_range &&
                 (op_r == OP_SET || op_r == OP_CLEAR || op_r == OP_WRITE);
    s_new_word = rd_data_r;
    s_new_word[s_bit] = s_nv;
  end

  // Scan over the words that hold live entries.
  always_comb begin
    issue = cmd.scan_run && (rbase_r < live_n_w);
    rem   = live_n_w - rbase_r;
    if (rem >= WORD_SZ) begin
      plim_nxt = (BIT_W + 1)'(WORD_BITS);
    end else begin
      plim_nxt = rem[BIT_W:0];
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (BIT_W + 1)'(j) < plim_r;
    end
    // A find with the selector low looks for a set entry; claim looks for clear.
    want = (op_r == OP_FIND) ? !sclr_r : 1'b0;
    cand = (want ? rd_data_r : ~rd_data_r) & mask;
    ff   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        ff = BIT_W'(j);
      end
    end
    hit        = dv_r && (op_r != OP_FILL) && (|cand);
    scan_end   = !dv_r && !(rbase_r < live_n_w);
    found_sum  = pb_r + BASE_W'(ff);
    fill_word  = (rd_data_r & ~mask) | (val_r ? mask : '0);
    claim_word = rd_data_r;
    claim_word[ff] = 1'b1;
  end

  assign stat.clear_last = (clr_ptr_r == LAST_W);
  assign stat.op_scan    = (in_operation == OP_FILL) || (in_operation == OP_FIND) ||
                           (in_operation == OP_CLAIM);
  assign stat.hit        = hit;
  assign stat.scan_end   = scan_end;

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rp_r;
    if (cmd.rd_single) begin
      rd_en   = 1'b1;
      rd_addr = s_word;
    end else if (issue) begin
      rd_en = 1'b1;
    end

    we      = 1'b0;
    wr_addr = pw_r;
    wr_data = fill_word;
    if (cmd.clear_step) begin
      we      = 1'b1;
      wr_addr = clr_ptr_r;
      wr_data = '0;
    end else if (cmd.exec_single && s_modify) begin
      we      = 1'b1;
      wr_addr = s_word;
      wr_data = s_new_word;
    end else if (cmd.scan_run && dv_r && op_r == OP_FILL) begin
      we = 1'b1;
    end else if (cmd.scan_run && hit && op_r == OP_CLAIM) begin
      we      = 1'b1;
      wr_data = claim_word;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      dv_r      <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      if (cmd.take) begin
        dv_r <= 1'b0;
      end else begin
        dv_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rp_r    <= '0;
      rbase_r <= '0;
    end else if (issue) begin
      rp_r    <= rp_r + 1'b1;
      rbase_r <= rbase_r + WORD_SZ;
      pw_r    <= rp_r;
      pb_r    <= rbase_r;
      plim_r  <= plim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_single) begin
      res_status_r <= STATUS_OK;
      res_bit_r    <= 1'b0;
      res_chg_r    <= 1'b0;
      res_found_r  <= '0;
      if (op_r == OP_GET || op_r == OP_SET || op_r == OP_CLEAR || op_r == OP_WRITE) begin
        if (!s_in_range) begin
          res_status_r <= STATUS_RANGE;
        end else if (op_r == OP_GET) begin
          res_bit_r <= s_old;
        end else begin
          res_chg_r <= (s_old != s_nv);
        end
      end
    end else if (cmd.scan_run && hit) begin
      res_status_r <= STATUS_OK;
      res_bit_r    <= 1'b0;
      res_chg_r    <= (op_r == OP_CLAIM);
      res_found_r  <= found_sum[IDX_W-1:0];
    end else if (cmd.scan_run && scan_end) begin
      res_status_r <= (op_r == OP_FILL) ? STATUS_OK : STATUS_NONE;
      res_bit_r    <= 1'b0;
      res_chg_r    <= 1'b0;
      res_found_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= res_status_r;
      out_bit_value   <= res_bit_r;
      out_changed     <= res_chg_r;
      out_found_index <= res_found_r;
    end
  end

endmodule

@@ hw/rtl/bitmap_allocator_core.sv @@
`timescale 1ns / 1ps
// Get, set, clear, write and unused codes read the addressed word, then update it, then load
// the result once the output register is free. Fill, find and claim read one memory word per
// cycle and stop at the first hit or after a pass over the live words, which number
// ceil(min(entry_count, MAX_ENTRIES)/WORD_BITS), 8 by default. Each next word is taken in the
// cycle after the result is loaded. Reset (synchronous, rst_n low) clears all NUM_WORDS words
// (8 by default) one word per cycle, during which no word is accepted.

module bitmap_allocator_core #(
  parameter int MAX_ENTRIES = bmalloc_pkg::MAX_ENTRIES_DEF,
  parameter int WORD_BITS   = bmalloc_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bmalloc_pkg::CNT_W-1:0] cfg_wdata,
  bmalloc_in_if.sink                    in_ch,
  bmalloc_out_if.source                 out_ch
);
  import bmalloc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmalloc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_ch.operation),
    .in_index        (in_ch.index),
    .in_value        (in_ch.value),
    .in_search_clear (in_ch.search_clear),
    .out_status      (out_ch.status),
    .out_bit_value   (out_ch.bit_value),
    .out_changed     (out_ch.changed),
    .out_found_index (out_ch.found_index)
  );

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // Only one word is in the block at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted while busy");

  // A failed request changes nothing and reports no index.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STATUS_OK) |->
      (!out_ch.changed && !out_ch.bit_value && out_ch.found_index == '0))
    else $error("failed request reports a change or an index");

  // The clearing pass keeps the input closed.
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ch.ready)
    else $error("word accepted during clearing pass");

endmodule

@@ dv/bitmap_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module bitmap_allocator_core_tb;
  import bmalloc_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 3'd7;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] index;
    logic             value;
    logic             search_clear;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bit_value;
    logic                changed;
    logic [IDX_W-1:0]    found_index;
  } alloc_resp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  bmalloc_in_if  in_if ();
  bmalloc_out_if out_if ();

  bitmap_allocator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source)
  );

  // Shadow copy of the bitmap and of the entry count register.
  logic [MAX_ENTRIES_DEF-1:0] alloc_flags;
  logic [CNT_W-1:0]           alloc_count;

  alloc_req_t  pending_reqs[$];
  alloc_resp_t expected_resps[$];

  logic in_fire;
  bit   idle_on;
  int   gap_left;
  int   stall_left;
  int   quiet_cycles;
  int   errors;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int rand_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int live_entries();
    return (alloc_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(alloc_count);
  endfunction

  // Applies one request to the shadow bitmap and returns the response it should give.
  function automatic alloc_resp_t predict_alloc(alloc_req_t req);
    alloc_resp_t r;
    int          n;
    int          i;
    bit          hit;
    logic        want;
    logic        nv;
    r   = '0;
    n   = live_entries();
    hit = 1'b0;
    case (req.operation)
      OP_GET, OP_SET, OP_CLEAR, OP_WRITE: begin
        if (int'(req.index) >= n) begin
          r.status = STATUS_RANGE;
        end else if (req.operation == OP_GET) begin
          r.bit_value = alloc_flags[req.index];
        end else begin
          nv = (req.operation == OP_SET) ? 1'b1 :
               (req.operation == OP_CLEAR) ? 1'b0 : req.value;
          r.changed = (alloc_flags[req.index] != nv);
          alloc_flags[req.index] = nv;
        end
      end
      OP_FILL: begin
        for (i = 0; i < n; i++) alloc_flags[i] = req.value;
      end
      OP_FIND, OP_CLAIM: begin
        // A claim always hunts for a clear entry, whatever the selector says.
        want = (req.operation == OP_CLAIM) ? 1'b0 : !req.search_clear;
        for (i = 0; i < n && !hit; i++) begin
          if (alloc_flags[i] == want) begin
            hit = 1'b1;
            r.found_index = 8'(i);
          end
        end
        if (!hit) begin
          r.status = STATUS_NONE;
        end else if (req.operation == OP_CLAIM) begin
          alloc_flags[r.found_index] = 1'b1;
          r.changed = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic push_req(logic [OP_W-1:0] op, int idx, logic val, logic sclr);
    alloc_req_t req;
    req.operation    = op;
    req.index        = 8'(idx);
    req.value        = val;
    req.search_clear = sclr;
    pending_reqs.push_back(req);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    alloc_count = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-aimed requests, with a share of out-of-range indices and fill/clear/claim-or-find
  // runs that push the search deep into the bitmap.
  task automatic gen_random(int items);
    int n;
    int k;
    int r;
    int idx;
    n = live_entries();
    k = 0;
    while (k < items) begin
      if (n > 0 && $urandom_range(0, 19) == 0) begin
        idx = $urandom_range(0, n - 1);
        push_req(OP_FILL, $urandom_range(0, 255), 1'b1, 1'($urandom));
        push_req(OP_CLEAR, idx, 1'($urandom), 1'($urandom));
        push_req(($urandom_range(0, 1) == 0) ? OP_CLAIM : OP_FIND, $urandom_range(0, 255),
                 1'($urandom), 1'b1);
        k += 3;
      end else begin
        if (n > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, n - 1);
        else idx = $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 18)      push_req(OP_GET, idx, 1'($urandom), 1'($urandom));
        else if (r < 32) push_req(OP_SET, idx, 1'($urandom), 1'($urandom));
        else if (r < 48) push_req(OP_CLEAR, idx, 1'($urandom), 1'($urandom));
        else if (r < 62) push_req(OP_WRITE, idx, 1'($urandom), 1'($urandom));
        else if (r < 67) push_req(OP_FILL, idx, 1'($urandom), 1'($urandom));
        else if (r < 80) push_req(OP_FIND, idx, 1'($urandom), 1'($urandom));
        else if (r < 97) push_req(OP_CLAIM, idx, 1'($urandom), 1'($urandom));
        else             push_req(OP_NONE, idx, 1'($urandom), 1'($urandom));
        k++;
      end
    end
  endtask

  // Request driver.
  always @(negedge clk) begin : drive_req
    logic       v_next;
    alloc_req_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_fire && pending_reqs.size() != 0) pending_reqs.delete(0);
      if (in_if.valid && !in_fire) begin
        v_next = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        v_next = 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs[0];
        in_if.operation    <= nxt.operation;
        in_if.index        <= nxt.index;
        in_if.value        <= nxt.value;
        in_if.search_clear <= nxt.search_clear;
        v_next   = 1'b1;
        gap_left = rand_gap();
      end else begin
        v_next = 1'b0;
      end
      in_if.valid <= v_next;
    end
  end

  // Response back-pressure.
  always @(negedge clk) begin : drive_ready
    logic r_next;
    if (stall_left > 0) begin
      stall_left--;
      r_next = 1'b0;
    end else begin
      r_next = 1'b1;
      if (idle_on && $urandom_range(0, 2) == 0) stall_left = rand_gap();
    end
    out_if.ready <= r_next;
  end

  always @(posedge clk) begin : monitor
    alloc_req_t  req;
    alloc_resp_t exp_r;
    bit          any_fire;
    any_fire = 1'b0;
    if (rst_n && out_if.valid && out_if.ready) begin
      any_fire = 1'b1;
      if (expected_resps.size() == 0) begin
        $error("response word with no request outstanding");
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        check_field("status", 8'(exp_r.status), 8'(out_if.status));
        check_field("bit_value", 8'(exp_r.bit_value), 8'(out_if.bit_value));
        check_field("changed", 8'(exp_r.changed), 8'(out_if.changed));
        check_field("found_index", exp_r.found_index, out_if.found_index);
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      any_fire = 1'b1;
      req.operation    = in_if.operation;
      req.index        = in_if.index;
      req.value        = in_if.value;
      req.search_clear = in_if.search_clear;
      expected_resps.push_back(predict_alloc(req));
    end
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (any_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bitmap_allocator_core test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int counts[9];
    int p;
    counts = '{256, 1, 0, 8, 33, 200, 511, 256, 97};
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_GET;
    in_if.index        = '0;
    in_if.value        = 1'b0;
    in_if.search_clear = 1'b0;
    out_if.ready       = 1'b0;
    in_fire            = 1'b0;
    idle_on            = 1'b1;
    gap_left           = 0;
    stall_left         = 0;
    quiet_cycles       = 0;
    errors             = 0;
    alloc_flags        = '0;
    alloc_count        = CNT_RESET;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset entry count.
    push_req(OP_GET, 0, 1'b0, 1'b0);
    push_req(OP_SET, 0, 1'b0, 1'b0);
    push_req(OP_SET, 0, 1'b0, 1'b0);
    push_req(OP_GET, 0, 1'b1, 1'b1);
    push_req(OP_CLEAR, 0, 1'b1, 1'b0);
    push_req(OP_CLEAR, 0, 1'b0, 1'b0);
    push_req(OP_WRITE, 255, 1'b1, 1'b0);
    push_req(OP_WRITE, 255, 1'b1, 1'b1);
    push_req(OP_GET, 255, 1'b0, 1'b0);
    push_req(OP_WRITE, 255, 1'b0, 1'b0);
    push_req(OP_SET, 100, 1'b0, 1'b0);
    push_req(OP_FIND, 0, 1'b0, 1'b1);
    push_req(OP_FIND, 0, 1'b0, 1'b0);
    push_req(OP_CLAIM, 0, 1'b0, 1'b0);
    push_req(OP_CLAIM, 0, 1'b0, 1'b1);
    push_req(OP_FILL, 0, 1'b1, 1'b0);
    push_req(OP_CLAIM, 0, 1'b0, 1'b0);
    push_req(OP_FIND, 0, 1'b0, 1'b1);
    push_req(OP_CLEAR, 200, 1'b0, 1'b0);
    push_req(OP_CLAIM, 255, 1'b1, 1'b0);
    push_req(OP_FILL, 0, 1'b0, 1'b0);
    push_req(OP_FIND, 0, 1'b0, 1'b0);
    push_req(OP_NONE, 255, 1'b1, 1'b1);
    push_req(OP_GET, 128, 1'b0, 1'b0);
    drain();

    // With no entries in use every index is out of range and searches fail.
    write_count(9'd0);
    push_req(OP_GET, 0, 1'b0, 1'b0);
    push_req(OP_FILL, 0, 1'b1, 1'b0);
    push_req(OP_FIND, 0, 1'b0, 1'b1);
    push_req(OP_CLAIM, 0, 1'b0, 1'b0);
    drain();

    for (p = 0; p < 9; p++) begin
      write_count(CNT_W'(counts[p]));
      idle_on = (p % 3 != 2);
      gen_random(215);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("bitmap_allocator_core test passed");
    end else begin
      $display("bitmap_allocator_core test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bmalloc_pkg.sv
hw/rtl/bmalloc_in_if.sv
hw/rtl/bmalloc_out_if.sv
hw/rtl/bmalloc_ctrl.sv
hw/rtl/bmalloc_dp.sv
hw/rtl/bitmap_allocator_core.sv
dv/bitmap_allocator_core_tb.sv
